// ===== src/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/srpd_pkg.sv =====
// Package: types, codes and timestamp unpacking for the sensor record deframer.
package srpd_pkg;

  localparam logic [7:0] TYPE_FULL  = 8'h02;
  localparam logic [7:0] TYPE_WIND  = 8'h03;
  localparam logic [7:0] TYPE_ENV   = 8'h04;
  localparam logic [2:0] SLOT_FIRST_ENV = 3'd4;
  localparam logic [2:0] SLOT_LAST_WIND = 3'd3;
  localparam logic [2:0] SLOT_LAST_ALL  = 3'd7;

  typedef enum logic [1:0] {
    KIND_STAMP = 2'd0,
    KIND_WORD  = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_TRUNC = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [7:0]  packet_type;
    logic [12:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  reading_number;
    logic [2:0]  word_slot;
    logic [15:0] word_value;
    logic        packet_last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } res_t;

  // Unpack the bit-packed timestamp; ext_byte only counts when ext is set.
  function automatic item_t stamp_item(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2, input logic [7:0] b3,
                                       input logic [7:0] ext_byte, input logic ext,
                                       input logic [7:0] ptype, input logic last);
    item_t it;
    it                = '0;
    it.result_kind    = KIND_STAMP;
    it.packet_type    = ptype;
    it.year           = {(ext ? ext_byte[7:6] : 2'b00), b3[6:0], b2[7:4]};
    it.month          = b2[3:0];
    it.day_of_month   = b1[7:3];
    it.hour           = {b1[2:0], b0[7:6]};
    it.minute         = b0[5:0];
    it.second         = ext ? ext_byte[5:0] : 6'd0;
    it.packet_last    = last;
    return it;
  endfunction

endpackage

// ===== src/srpd_byte_if.sv =====
// Input channel: one stream byte per item.
interface srpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== src/srpd_rec_if.sv =====
// Result channel: one decoded record item.
interface srpd_rec_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  packet_type;
  logic [12:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [4:0]  reading_number;
  logic [2:0]  word_slot;
  logic [15:0] word_value;
  logic        packet_last;

  modport source (output valid, output result_kind, output packet_type, output year,
                  output month, output day_of_month, output hour, output minute,
                  output second, output reading_number, output word_slot,
                  output word_value, output packet_last, input ready);
  modport sink   (input valid, input result_kind, input packet_type, input year,
                  input month, input day_of_month, input hour, input minute,
                  input second, input reading_number, input word_slot,
                  input word_value, input packet_last, output ready);
endinterface

// ===== src/srpd_decode.sv =====
// Packet parser: state registers and single-pass decode of each accepted byte.
`include "assert_macros.svh"

module srpd_decode import srpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] data_byte,
  output res_t       res
);

  logic [7:0] pos_r, pos_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] type_r, type_nxt;
  logic [4:0] rdg_r, rdg_nxt;
  logic [2:0] slot_r, slot_nxt;
  logic       skip_r, skip_nxt;
  logic [7:0] stamp_r [4];
  logic [7:0] hold_r;
  logic       stamp_we;
  logic       hold_we;
  logic [1:0] stamp_idx;
  logic       last;
  logic       ext;
  logic       bad_type;
  logic       end_pkt;

  assign last      = ({1'b0, pos_r} + 9'd1) >= {1'b0, len_r};
  assign ext       = stamp_r[3][7];
  assign bad_type  = (type_r != TYPE_FULL) && (type_r != TYPE_WIND) && (type_r != TYPE_ENV);
  assign stamp_idx = pos_r[1:0] + 2'd2;

  always_comb begin
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    type_nxt = type_r;
    rdg_nxt  = rdg_r;
    slot_nxt = slot_r;
    skip_nxt = skip_r;
    stamp_we = 1'b0;
    hold_we  = 1'b0;
    end_pkt  = 1'b0;
    res      = '0;
    res.item.packet_type = type_r;
    if (acc) begin
      if (pos_r == 8'd0) begin
        type_nxt = data_byte;
        rdg_nxt  = '0;
        slot_nxt = (data_byte == TYPE_ENV) ? SLOT_FIRST_ENV : 3'd0;
        skip_nxt = 1'b0;
        pos_nxt  = 8'd1;
      end else if (pos_r == 8'd1) begin
        len_nxt = data_byte;
        pos_nxt = 8'd2;
      end else if (pos_r <= 8'd5) begin
        stamp_we = 1'b1;
        if (pos_r == 8'd5 && !data_byte[7]) begin
          res.valid = 1'b1;
          res.item  = stamp_item(stamp_r[0], stamp_r[1], stamp_r[2], data_byte,
                                 8'd0, 1'b0, type_r, last);
          if (last) end_pkt = 1'b1;
          else pos_nxt = pos_r + 8'd1;
        end else begin
          pos_nxt = pos_r + 8'd1;
        end
      end else if (pos_r == 8'd6 && ext) begin
        res.valid = 1'b1;
        res.item  = stamp_item(stamp_r[0], stamp_r[1], stamp_r[2], stamp_r[3],
                               data_byte, 1'b1, type_r, last);
        if (last) end_pkt = 1'b1;
        else pos_nxt = pos_r + 8'd1;
      end else if (bad_type) begin
        // one error per packet, then swallow bytes to the end
        if (!skip_r) begin
          res.valid = 1'b1;
          res.item.result_kind = KIND_ERROR;
          res.item.packet_last = 1'b1;
          skip_nxt = 1'b1;
        end
        if (last) end_pkt = 1'b1;
        else pos_nxt = pos_r + 8'd1;
      end else begin
        res.item.reading_number = rdg_r;
        res.item.word_slot      = slot_r;
        // low byte sits at even offset from the end of the timestamp
        if (pos_r[0] == ext) begin
          hold_we = 1'b1;
          if (last) begin
            res.valid = 1'b1;
            res.item.result_kind = KIND_TRUNC;
            res.item.word_value  = {8'd0, data_byte};
            res.item.packet_last = 1'b1;
            end_pkt = 1'b1;
          end else begin
            pos_nxt = pos_r + 8'd1;
          end
        end else begin
          res.valid = 1'b1;
          res.item.result_kind = KIND_WORD;
          res.item.word_value  = {data_byte, hold_r};
          res.item.packet_last = last;
          if (slot_r == ((type_r == TYPE_WIND) ? SLOT_LAST_WIND : SLOT_LAST_ALL)) begin
            slot_nxt = (type_r == TYPE_ENV) ? SLOT_FIRST_ENV : 3'd0;
            rdg_nxt  = rdg_r + 5'd1;
          end else begin
            slot_nxt = slot_r + 3'd1;
          end
          if (last) end_pkt = 1'b1;
          else pos_nxt = pos_r + 8'd1;
        end
      end
      if (end_pkt) begin
        pos_nxt  = 8'd0;
        rdg_nxt  = '0;
        slot_nxt = '0;
        skip_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      len_r  <= '0;
      type_r <= '0;
      rdg_r  <= '0;
      slot_r <= '0;
      skip_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      type_r <= type_nxt;
      rdg_r  <= rdg_nxt;
      slot_r <= slot_nxt;
      skip_r <= skip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stamp_we) stamp_r[stamp_idx] <= data_byte;
    if (hold_we) hold_r <= data_byte;
  end

  `ASSERT_IMPL(a_err_is_last, acc && res.valid && (res.item.result_kind == KIND_ERROR || res.item.result_kind == KIND_TRUNC), res.item.packet_last, "error or truncated item without packet_last")
  `ASSERT_NEXT(a_last_rewinds, acc && res.valid && res.item.packet_last && res.item.result_kind != KIND_ERROR, pos_r == 8'd0, "packet_last item did not return parser to type byte")
  `ASSERT_NEXT(a_skip_silent, acc && res.valid && res.item.result_kind == KIND_ERROR, pos_r == 8'd0 || skip_r, "error item not followed by skipping")

endmodule

// ===== src/srpd_out_reg.sv =====
// Result register: holds one decoded item until the sink takes it.
`include "assert_macros.svh"

module srpd_out_reg import srpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  res_t       res,
  input  logic       acc,
  output logic       take_ok,
  srpd_rec_if.source out_ch
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  assign take_ok   = !valid_r || out_ch.ready;
  assign load      = acc && res.valid;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) item_r <= res.item;
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.result_kind    = item_r.result_kind;
  assign out_ch.packet_type    = item_r.packet_type;
  assign out_ch.year           = item_r.year;
  assign out_ch.month          = item_r.month;
  assign out_ch.day_of_month   = item_r.day_of_month;
  assign out_ch.hour           = item_r.hour;
  assign out_ch.minute         = item_r.minute;
  assign out_ch.second         = item_r.second;
  assign out_ch.reading_number = item_r.reading_number;
  assign out_ch.word_slot      = item_r.word_slot;
  assign out_ch.word_value     = item_r.word_value;
  assign out_ch.packet_last    = item_r.packet_last;

  `ASSERT_IMPL(a_no_overwrite, valid_r && !out_ch.ready, !load, "result register overwritten while stalled")

endmodule

// ===== src/sensor_record_packet_deframer.sv =====
// Top level of the sensor record packet deframer.
// A byte that completes a result shows it on out_ch in the cycle after acceptance.
// Throughput: one byte per cycle; the single result register is the only buffer, and a
// byte is taken whenever that register is empty or being emptied in the same cycle.
// Reset (synchronous, rst_n low): parser expects a type byte, counters clear, output empty.
module sensor_record_packet_deframer import srpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  srpd_byte_if.sink  in_ch,
  srpd_rec_if.source out_ch
);

  logic acc;
  logic take_ok;
  res_t res;

  assign in_ch.ready = take_ok;
  assign acc         = in_ch.valid && take_ok;

  srpd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .data_byte (in_ch.data_byte),
    .res       (res)
  );

  srpd_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .res     (res),
    .acc     (acc),
    .take_ok (take_ok),
    .out_ch  (out_ch)
  );

endmodule

// ===== tb/sensor_record_packet_deframer_tb.sv =====
// Self-checking testbench for the sensor record packet deframer.
module sensor_record_packet_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srpd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int REPORT_CAP     = 100;

  logic clk;
  logic rst_n;

  srpd_byte_if stream_ch();
  srpd_rec_if  record_ch();

  sensor_record_packet_deframer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (stream_ch),
    .out_ch (record_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Decoder state mirrored in the testbench
  logic [7:0] dec_pos;
  logic [7:0] dec_len;
  logic [7:0] dec_type;
  logic [7:0] dec_stamp [4];
  logic [7:0] dec_hold;
  logic [4:0] dec_reading;
  logic [2:0] dec_slot;
  logic       dec_skip;

  item_t pending_records[$];

  int src_idle_pct;
  int snk_idle_pct;
  int idle_cycles;
  int fail_count;
  int bytes_sent;
  int packets_sent;
  int records_checked;
  int kind_seen [4];

  function automatic void end_packet();
    dec_pos     = 8'd0;
    dec_reading = 5'd0;
    dec_slot    = 3'd0;
    dec_skip    = 1'b0;
  endfunction

  function automatic void step_position(input logic last);
    if (last) begin
      end_packet();
    end else begin
      dec_pos = dec_pos + 8'd1;
    end
  endfunction

  function automatic void emit_timestamp(input logic [7:0] ext_byte, input logic ext,
                                         input logic last);
    item_t rec;
    rec              = '0;
    rec.result_kind  = KIND_STAMP;
    rec.packet_type  = dec_type;
    rec.year[3:0]    = dec_stamp[2][7:4];
    rec.year[10:4]   = dec_stamp[3][6:0];
    rec.year[12:11]  = ext ? ext_byte[7:6] : 2'b00;
    rec.month        = dec_stamp[2][3:0];
    rec.day_of_month = dec_stamp[1][7:3];
    rec.hour         = {dec_stamp[1][2:0], dec_stamp[0][7:6]};
    rec.minute       = dec_stamp[0][5:0];
    rec.second       = ext ? ext_byte[5:0] : 6'd0;
    rec.packet_last  = last;
    pending_records.push_back(rec);
    step_position(last);
  endfunction

  // Advance the mirrored decoder by one accepted byte and queue what it yields
  function automatic void decode_byte(input logic [7:0] b);
    item_t      rec;
    logic [7:0] p;
    logic [7:0] hdr;
    logic [7:0] offset;
    logic [2:0] final_slot;
    logic       last;
    logic       ext;
    rec = '0;
    p   = dec_pos;
    if (p == 8'd0) begin
      dec_type    = b;
      dec_reading = 5'd0;
      dec_slot    = (b == TYPE_ENV) ? SLOT_FIRST_ENV : 3'd0;
      dec_skip    = 1'b0;
      dec_pos     = 8'd1;
    end else if (p == 8'd1) begin
      dec_len = b;
      dec_pos = 8'd2;
    end else begin
      rec.packet_type = dec_type;
      last = ({1'b0, p} + 9'd1) >= {1'b0, dec_len};
      if (p <= 8'd5) begin
        dec_stamp[2'(p - 8'd2)] = b;
        if (p == 8'd5 && !b[7]) begin
          emit_timestamp(8'd0, 1'b0, last);
        end else begin
          dec_pos = p + 8'd1;
        end
      end else begin
        ext = dec_stamp[3][7];
        if (p == 8'd6 && ext) begin
          emit_timestamp(b, 1'b1, last);
        end else if (dec_type != TYPE_FULL && dec_type != TYPE_WIND &&
                     dec_type != TYPE_ENV) begin
          // unsupported type: one error right after the stamp, then silent skip
          if (!dec_skip) begin
            rec.result_kind = KIND_ERROR;
            rec.packet_last = 1'b1;
            pending_records.push_back(rec);
            dec_skip = 1'b1;
          end
          step_position(last);
        end else begin
          hdr = ext ? 8'd7 : 8'd6;
          offset = p - hdr;
          rec.reading_number = dec_reading;
          rec.word_slot      = dec_slot;
          if (!offset[0]) begin
            dec_hold = b;
            if (last) begin
              rec.result_kind = KIND_TRUNC;
              rec.word_value  = {8'd0, b};
              rec.packet_last = 1'b1;
              pending_records.push_back(rec);
              end_packet();
            end else begin
              dec_pos = p + 8'd1;
            end
          end else begin
            rec.result_kind = KIND_WORD;
            rec.word_value  = {b, dec_hold};
            rec.packet_last = last;
            pending_records.push_back(rec);
            final_slot = (dec_type == TYPE_WIND) ? SLOT_LAST_WIND : SLOT_LAST_ALL;
            if (dec_slot == final_slot) begin
              dec_slot    = (dec_type == TYPE_ENV) ? SLOT_FIRST_ENV : 3'd0;
              dec_reading = dec_reading + 5'd1;
            end else begin
              dec_slot = dec_slot + 3'd1;
            end
            step_position(last);
          end
        end
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      if (fail_count < REPORT_CAP) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
      end
      fail_count++;
    end
  endfunction

  function automatic void check_record();
    item_t want;
    if (pending_records.size() == 0) begin
      if (fail_count < REPORT_CAP) begin
        $error("record item with nothing expected: kind %0d type %0d",
               record_ch.result_kind, record_ch.packet_type);
      end
      fail_count++;
    end else begin
      want = pending_records.pop_front();
      check_field("result_kind", 32'(want.result_kind), 32'(record_ch.result_kind));
      check_field("packet_type", 32'(want.packet_type), 32'(record_ch.packet_type));
      check_field("year", 32'(want.year), 32'(record_ch.year));
      check_field("month", 32'(want.month), 32'(record_ch.month));
      check_field("day_of_month", 32'(want.day_of_month), 32'(record_ch.day_of_month));
      check_field("hour", 32'(want.hour), 32'(record_ch.hour));
      check_field("minute", 32'(want.minute), 32'(record_ch.minute));
      check_field("second", 32'(want.second), 32'(record_ch.second));
      check_field("reading_number", 32'(want.reading_number),
                  32'(record_ch.reading_number));
      check_field("word_slot", 32'(want.word_slot), 32'(record_ch.word_slot));
      check_field("word_value", 32'(want.word_value), 32'(record_ch.word_value));
      check_field("packet_last", 32'(want.packet_last), 32'(record_ch.packet_last));
      kind_seen[want.result_kind]++;
      records_checked++;
    end
  endfunction

  // Outputs are checked before the byte of the same edge is decoded;
  // a result never shows up on the edge its byte is taken.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (record_ch.valid === 1'b1 && record_ch.ready === 1'b1) begin
        check_record();
        idle_cycles = 0;
      end else if (!(stream_ch.valid === 1'b1 && stream_ch.ready === 1'b1)) begin
        idle_cycles = idle_cycles + 1;
      end
      if (stream_ch.valid === 1'b1 && stream_ch.ready === 1'b1) begin
        decode_byte(stream_ch.data_byte);
        idle_cycles = 0;
      end
    end
  end

  initial begin
    record_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      record_ch.ready <= (rst_n === 1'b1) && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("FAILED: results differ");
    $finish;
  end

  // Entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      stream_ch.valid <= 1'b0;
      @(negedge clk);
    end
    stream_ch.valid     <= 1'b1;
    stream_ch.data_byte <= b;
    @(posedge clk);
    while (stream_ch.ready !== 1'b1) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    stream_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_records.size() != 0) @(negedge clk);
  endtask

  // stamp[31] selects the extended timestamp; short lengths still carry the full header
  task automatic send_packet(input logic [7:0] ptype, input logic [7:0] plen,
                             input logic [31:0] stamp, input logic [7:0] ext_byte,
                             input bit rand_fill, input logic [7:0] fill);
    int hdr;
    int total;
    hdr   = stamp[31] ? 7 : 6;
    total = (plen > hdr) ? plen : hdr;
    send_byte(ptype);
    send_byte(plen);
    for (int i = 0; i < 4; i++) send_byte(stamp[8*i +: 8]);
    if (stamp[31]) send_byte(ext_byte);
    for (int i = hdr; i < total; i++) begin
      send_byte(rand_fill ? 8'($urandom_range(255)) : fill);
    end
    packets_sent++;
  endtask

  task automatic test_stamp_extremes();
    send_packet(TYPE_WIND, 8'd0, 32'h7FFF_FFFF, 8'h00, 1'b0, 8'h00);
    send_packet(TYPE_ENV, 8'd7, 32'hFFFF_FFFF, 8'hFF, 1'b0, 8'h00);
    send_packet(TYPE_FULL, 8'd6, 32'h8000_0000, 8'h00, 1'b0, 8'h00);
  endtask

  task automatic test_reading_words();
    // one full reading plus a word of the next
    send_packet(TYPE_FULL, 8'd24, 32'h1234_5678, 8'h00, 1'b1, 8'h00);
    // one reading then a lone low byte
    send_packet(TYPE_WIND, 8'd16, 32'h9ABC_DEF0, 8'h5A, 1'b0, 8'hFF);
    send_packet(TYPE_ENV, 8'd14, 32'h0000_0000, 8'h00, 1'b0, 8'h00);
  endtask

  task automatic test_unsupported_type();
    send_packet(8'hFF, 8'd10, 32'h0102_0304, 8'h00, 1'b1, 8'h00);
    send_packet(8'h00, 8'd6, 32'h0000_0000, 8'h00, 1'b0, 8'h00);
    send_packet(8'h01, 8'd7, 32'hC000_0000, 8'hC3, 1'b0, 8'h00);
    send_packet(8'h05, 8'd20, 32'h8765_4321, 8'h3F, 1'b1, 8'h00);
  endtask

  task automatic test_longest_packets();
    send_packet(TYPE_WIND, 8'd255, 32'h0F0F_0F0F, 8'h00, 1'b1, 8'h00);
    send_packet(TYPE_FULL, 8'd255, 32'hF0F0_F0F0, 8'h81, 1'b1, 8'h00);
    send_packet(TYPE_ENV, 8'd254, 32'h5555_AAAA, 8'h00, 1'b1, 8'h00);
  endtask

  task automatic send_random_packet();
    logic [7:0]  ptype;
    logic [7:0]  plen;
    logic [31:0] stamp;
    logic        ext;
    int          hdr;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 85) begin
      case ($urandom_range(2))
        0:       ptype = TYPE_FULL;
        1:       ptype = TYPE_WIND;
        default: ptype = TYPE_ENV;
      endcase
    end else begin
      ptype = 8'($urandom_range(255));
    end
    ext      = 1'($urandom_range(1));
    hdr      = ext ? 7 : 6;
    stamp    = $urandom;
    stamp[31] = ext;
    pick = $urandom_range(99);
    if (pick < 10) begin
      plen = 8'($urandom_range(255));
    end else if (pick < 14) begin
      plen = 8'($urandom_range(255, 200));
    end else begin
      plen = 8'(hdr + $urandom_range(40));
    end
    send_packet(ptype, plen, stamp, 8'($urandom_range(255)), 1'b1, 8'h00);
  endtask

  task automatic test_random_stream(input int n_bytes);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      send_random_packet();
      if ($urandom_range(19) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    stream_ch.valid     = 1'b0;
    stream_ch.data_byte = 8'd0;
    src_idle_pct        = 37;
    snk_idle_pct        = 78;
    fail_count          = 0;
    bytes_sent          = 0;
    packets_sent        = 0;
    records_checked     = 0;
    kind_seen           = '{default: 0};
    dec_pos             = 8'd0;
    dec_len             = 8'd0;
    dec_type            = 8'd0;
    dec_reading         = 5'd0;
    dec_slot            = 3'd0;
    dec_skip            = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_stamp_extremes();
    test_reading_words();
    test_unsupported_type();
    test_longest_packets();
    test_random_stream(110);
    wait_drained();

    src_idle_pct = 78;
    snk_idle_pct = 37;
    test_random_stream(110);
    wait_drained();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_stream(110);

    stream_ch.valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d packets in %0d bytes; %0d results checked", packets_sent,
             bytes_sent, records_checked);
    $display("  %0d timestamps, %0d words, %0d type errors, %0d truncated bytes",
             kind_seen[KIND_STAMP], kind_seen[KIND_WORD], kind_seen[KIND_ERROR],
             kind_seen[KIND_TRUNC]);
    if (fail_count == 0 && pending_records.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
